>>> design/lmd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmd_pkg: shared types and constants of the 3x3 local maximum detector
// Field widths, report and register codes, controller/datapath command and
// status records.
// ----------------------------------------------------------------------------
package lmd_pkg;

  localparam int unsigned PixW     = 32;
  localparam int unsigned RowW     = 10;
  localparam int unsigned ColW     = 6;
  localparam int unsigned KindW    = 2;
  localparam int unsigned RowsW    = 11;
  localparam int unsigned ColsW    = 7;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned MaxRows  = 1024;

  localparam logic [KindW-1:0] KIND_PEAK = 2'd0;
  localparam logic [KindW-1:0] KIND_BEST = 2'd1;
  localparam logic [KindW-1:0] KIND_NONE = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_FRAME_ROWS = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_FRAME_COLS = 8'd1;

  localparam logic [RowsW-1:0] ResetRows = 11'd8;
  localparam logic [ColsW-1:0] ResetCols = 7'd8;

  typedef enum logic [1:0] {
    CHK_A,
    CHK_B,
    CHK_F
  } chk_kind_e;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_SLOT_A,
    EMIT_SLOT_B,
    EMIT_SUM
  } emit_sel_e;

  typedef struct packed {
    logic      load;
    logic      rd_en;
    logic      rd_other;
    logic      rd_flush;
    logic      lat_top;
    logic      shift;
    logic      wr;
    logic      chk_go;
    chk_kind_e chk;
    logic      chk_en;
    emit_sel_e emit;
    logic      emit_last;
    logic      j_clr;
    logic      j_inc;
    logic      advance;
  } lmd_cmd_t;

  typedef struct packed {
    logic r_ge1;
    logic c_ge1;
    logic c_last;
    logic last_px;
    logic j_ge1;
    logic j_end;
    logic hit_a;
    logic hit_b;
    logic out_free;
  } lmd_sts_t;

endpackage
`default_nettype wire

>>> design/lmd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmd_if: stream and configuration channels of the local maximum detector
// Valid/ready channels for pixel beats, report beats and register writes.
// ----------------------------------------------------------------------------
interface lmd_pix_if;
  logic                              valid;
  logic                              ready;
  logic signed [lmd_pkg::PixW-1:0]   pixel_value;
  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface lmd_rep_if;
  logic                              valid;
  logic                              ready;
  logic        [lmd_pkg::KindW-1:0]  report_kind;
  logic signed [lmd_pkg::PixW-1:0]   peak_value;
  logic        [lmd_pkg::RowW-1:0]   peak_row;
  logic        [lmd_pkg::ColW-1:0]   peak_col;
  logic                              last_of_run;
  modport source (output valid, output report_kind, output peak_value, output peak_row,
                  output peak_col, output last_of_run, input ready);
  modport sink   (input valid, input report_kind, input peak_value, input peak_row,
                  input peak_col, input last_of_run, output ready);
endinterface

interface lmd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [lmd_pkg::CfgIdxW-1:0]       index;
  logic [lmd_pkg::CfgDataW-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> design/lmd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmd_ram: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lmd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> design/lmd_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmd_dp: datapath of the local maximum detector
// Line store, 3x3 window, position and best trackers, report register.
// ----------------------------------------------------------------------------
module lmd_dp #(
  parameter int unsigned MaxCols = 64
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire lmd_pkg::lmd_cmd_t                 cmd_i,
  output      lmd_pkg::lmd_sts_t                 sts_o,
  input  wire logic signed [lmd_pkg::PixW-1:0]   pix_value_i,
  input  wire logic                              cfg_we_i,
  input  wire logic [lmd_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  wire logic [lmd_pkg::CfgDataW-1:0]      cfg_data_i,
  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      logic [lmd_pkg::KindW-1:0]         out_kind_o,
  output      logic signed [lmd_pkg::PixW-1:0]   out_value_o,
  output      logic [lmd_pkg::RowW-1:0]          out_row_o,
  output      logic [lmd_pkg::ColW-1:0]          out_col_o,
  output      logic                              out_last_o
);

  localparam int unsigned PixW  = lmd_pkg::PixW;
  localparam int unsigned RowW  = lmd_pkg::RowW;
  localparam int unsigned ColW  = lmd_pkg::ColW;
  localparam int unsigned RowsW = lmd_pkg::RowsW;
  localparam int unsigned ColsW = lmd_pkg::ColsW;
  localparam int unsigned KindW = lmd_pkg::KindW;
  localparam int unsigned CW    = (MaxCols > 1) ? $clog2(MaxCols) : 1;
  localparam int unsigned JW    = CW + 1;
  localparam int unsigned Depth = 2 * (2 ** CW);

  // configuration and position
  logic [RowsW-1:0] rows_q;
  logic [ColsW-1:0] cols_q;
  logic [RowW-1:0]  r_q, r_d;
  logic [CW-1:0]    c_q, c_d;
  logic [JW-1:0]    j_q;
  logic [RowsW-1:0] eff_rows;
  logic [JW-1:0]    eff_cols;

  // window and line store
  logic signed [PixW-1:0] pix_q;
  logic signed [PixW-1:0] top_q;
  logic signed [PixW-1:0] win_q [3][3];
  logic        [PixW-1:0] ram_rdata;
  logic        [CW:0]     ram_raddr;
  logic        [CW:0]     ram_waddr;

  // best tracker and check slots
  logic signed [PixW-1:0] best_q;
  logic [RowW-1:0]        best_row_q;
  logic [ColW-1:0]        best_col_q;
  logic                   best_found_q;
  logic                   hit_a_q, hit_b_q;
  logic signed [PixW-1:0] val_a_q, val_b_q;
  logic [RowW-1:0]        row_a_q, row_b_q;
  logic [ColW-1:0]        col_a_q, col_b_q;

  // report register
  logic                   out_valid_q;
  logic [KindW-1:0]       out_kind_q;
  logic signed [PixW-1:0] out_value_q;
  logic [RowW-1:0]        out_row_q;
  logic [ColW-1:0]        out_col_q;
  logic                   out_last_q;
  logic                   out_free;

  // check
  logic                   top_ok, bot_ok, left_ok, right_ok;
  logic [2:0]             row_ok, col_ok;
  logic signed [PixW-1:0] center;
  logic                   hit;
  logic [RowW-1:0]        chk_row;
  logic [ColW-1:0]        chk_col;
  logic [CW-1:0]          c_m1;
  logic [JW-1:0]          j_m1;
  logic                   r_ge2, c_ge2, j_ge2, r_last, oob;

  always_comb begin
    if (rows_q == '0) begin
      eff_rows = RowsW'(1);
    end else if (rows_q > RowsW'(lmd_pkg::MaxRows)) begin
      eff_rows = RowsW'(lmd_pkg::MaxRows);
    end else begin
      eff_rows = rows_q;
    end
    if (cols_q == '0) begin
      eff_cols = JW'(1);
    end else if (cols_q > ColsW'(MaxCols)) begin
      eff_cols = JW'(MaxCols);
    end else begin
      eff_cols = JW'(cols_q);
    end
  end

  assign r_ge2  = (r_q > RowW'(1));
  assign c_ge2  = (JW'(c_q) >= JW'(2));
  assign j_ge2  = (j_q >= JW'(2));
  assign r_last = ((RowsW'(r_q) + RowsW'(1)) == eff_rows);
  assign oob    = (RowsW'(r_q) >= eff_rows) || (JW'(c_q) >= eff_cols);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    sts_o          = '0;
    sts_o.r_ge1    = (r_q != '0);
    sts_o.c_ge1    = (c_q != '0);
    sts_o.c_last   = ((JW'(c_q) + JW'(1)) == eff_cols);
    sts_o.last_px  = r_last && sts_o.c_last;
    sts_o.j_ge1    = (j_q != '0);
    sts_o.j_end    = (j_q == eff_cols);
    sts_o.hit_a    = hit_a_q;
    sts_o.hit_b    = hit_b_q;
    sts_o.out_free = out_free;
  end

  // line store: rows alternate between the two halves
  assign ram_raddr = {r_q[0] ^ cmd_i.rd_other, cmd_i.rd_flush ? j_q[CW-1:0] : c_q};
  assign ram_waddr = {r_q[0], c_q};

  lmd_ram #(
    .Width (PixW),
    .Depth (Depth)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr),
    .waddr_i (ram_waddr),
    .wdata_i (pix_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // neighbor masks per check kind; window row 0 is top, column 0 is left
  assign c_m1 = c_q - CW'(1);
  assign j_m1 = j_q - JW'(1);

  always_comb begin
    top_ok   = 1'b0;
    bot_ok   = 1'b0;
    left_ok  = 1'b0;
    right_ok = 1'b0;
    chk_row  = r_q - RowW'(1);
    chk_col  = ColW'(c_m1);
    case (cmd_i.chk)
      lmd_pkg::CHK_A: begin
        top_ok   = r_ge2;
        bot_ok   = 1'b1;
        left_ok  = c_ge2;
        right_ok = 1'b1;
      end
      lmd_pkg::CHK_B: begin
        top_ok   = r_ge2;
        bot_ok   = 1'b1;
        left_ok  = (c_q != '0);
        right_ok = 1'b0;
        chk_col  = ColW'(c_q);
      end
      lmd_pkg::CHK_F: begin
        top_ok   = (r_q != '0);
        bot_ok   = 1'b0;
        left_ok  = j_ge2;
        right_ok = (j_q != eff_cols);
        chk_row  = r_q;
        chk_col  = ColW'(j_m1[CW-1:0]);
      end
      default: begin
        top_ok = 1'b0;
      end
    endcase
  end

  assign row_ok = {bot_ok, 1'b1, top_ok};
  assign col_ok = {right_ok, 1'b1, left_ok};
  assign center = win_q[1][1];

  always_comb begin
    hit = 1'b1;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        if (!(i == 1 && k == 1) && row_ok[i] && col_ok[k] && (win_q[i][k] >= center)) begin
          hit = 1'b0;
        end
      end
    end
  end

  // next position
  always_comb begin
    r_d = r_q;
    c_d = c_q;
    if (cmd_i.load && oob) begin
      r_d = '0;
      c_d = '0;
    end else if (cmd_i.advance) begin
      if (sts_o.last_px) begin
        r_d = '0;
        c_d = '0;
      end else if (sts_o.c_last) begin
        r_d = r_q + RowW'(1);
        c_d = '0;
      end else begin
        c_d = c_q + CW'(1);
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q       <= lmd_pkg::ResetRows;
      cols_q       <= lmd_pkg::ResetCols;
      r_q          <= '0;
      c_q          <= '0;
      j_q          <= '0;
      best_q       <= '0;
      best_row_q   <= '0;
      best_col_q   <= '0;
      best_found_q <= 1'b0;
      hit_a_q      <= 1'b0;
      hit_b_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      r_q <= r_d;
      c_q <= c_d;
      if (cmd_i.j_clr) begin
        j_q <= '0;
      end else if (cmd_i.j_inc) begin
        j_q <= j_q + JW'(1);
      end
      if (cmd_i.chk_go) begin
        if (cmd_i.chk == lmd_pkg::CHK_B) begin
          hit_b_q <= cmd_i.chk_en && hit;
        end else begin
          hit_a_q <= cmd_i.chk_en && hit;
        end
        if (cmd_i.chk == lmd_pkg::CHK_A) begin
          hit_b_q <= 1'b0;
        end
        if (cmd_i.chk_en && hit && (center > best_q)) begin
          best_q       <= center;
          best_row_q   <= chk_row;
          best_col_q   <= chk_col;
          best_found_q <= 1'b1;
        end
      end
      // restart the frame at its end
      if (cmd_i.advance && sts_o.last_px) begin
        best_q       <= '0;
        best_row_q   <= '0;
        best_col_q   <= '0;
        best_found_q <= 1'b0;
      end
      if (cfg_we_i && ((cfg_index_i == lmd_pkg::REG_FRAME_ROWS) ||
                       (cfg_index_i == lmd_pkg::REG_FRAME_COLS))) begin
        if (cfg_index_i == lmd_pkg::REG_FRAME_ROWS) begin
          rows_q <= cfg_data_i[RowsW-1:0];
        end else begin
          cols_q <= cfg_data_i[ColsW-1:0];
        end
        r_q          <= '0;
        c_q          <= '0;
        best_q       <= '0;
        best_row_q   <= '0;
        best_col_q   <= '0;
        best_found_q <= 1'b0;
      end
      if (cmd_i.emit != lmd_pkg::EMIT_NONE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pix_q <= pix_value_i;
    end
    if (cmd_i.lat_top) begin
      top_q <= ram_rdata;
    end
    if (cmd_i.shift) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= top_q;
      win_q[1][2] <= ram_rdata;
      win_q[2][2] <= pix_q;
    end
    if (cmd_i.chk_go) begin
      if (cmd_i.chk == lmd_pkg::CHK_B) begin
        val_b_q <= center;
        row_b_q <= chk_row;
        col_b_q <= chk_col;
      end else begin
        val_a_q <= center;
        row_a_q <= chk_row;
        col_a_q <= chk_col;
      end
    end
    case (cmd_i.emit)
      lmd_pkg::EMIT_SLOT_A: begin
        out_kind_q  <= lmd_pkg::KIND_PEAK;
        out_value_q <= val_a_q;
        out_row_q   <= row_a_q;
        out_col_q   <= col_a_q;
        out_last_q  <= cmd_i.emit_last;
      end
      lmd_pkg::EMIT_SLOT_B: begin
        out_kind_q  <= lmd_pkg::KIND_PEAK;
        out_value_q <= val_b_q;
        out_row_q   <= row_b_q;
        out_col_q   <= col_b_q;
        out_last_q  <= cmd_i.emit_last;
      end
      lmd_pkg::EMIT_SUM: begin
        out_kind_q  <= best_found_q ? lmd_pkg::KIND_BEST : lmd_pkg::KIND_NONE;
        out_value_q <= best_q;
        out_row_q   <= best_row_q;
        out_col_q   <= best_col_q;
        out_last_q  <= cmd_i.emit_last;
      end
      default: begin
        out_last_q <= out_last_q;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_kind_q;
  assign out_value_o = out_value_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_last_o  = out_last_q;

endmodule
`default_nettype wire

>>> design/lmd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmd_ctrl: sequencer of the local maximum detector
// Steps each pixel through line store reads, window shift, checks, reports
// and the end-of-frame flush.
// ----------------------------------------------------------------------------
module lmd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              pix_valid_i,
  output      logic              pix_ready_o,
  input  wire lmd_pkg::lmd_sts_t sts_i,
  output      lmd_pkg::lmd_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RD_TOP   = 4'd1;
  localparam logic [3:0] S_RD_MID   = 4'd2;
  localparam logic [3:0] S_SHIFT    = 4'd3;
  localparam logic [3:0] S_CHK_A    = 4'd4;
  localparam logic [3:0] S_DUMMY    = 4'd5;
  localparam logic [3:0] S_CHK_B    = 4'd6;
  localparam logic [3:0] S_EMIT_A   = 4'd7;
  localparam logic [3:0] S_EMIT_B   = 4'd8;
  localparam logic [3:0] S_FL_TOP   = 4'd9;
  localparam logic [3:0] S_FL_MID   = 4'd10;
  localparam logic [3:0] S_FL_SHIFT = 4'd11;
  localparam logic [3:0] S_FL_CHK   = 4'd12;
  localparam logic [3:0] S_FL_EMIT  = 4'd13;
  localparam logic [3:0] S_SUM      = 4'd14;
  localparam logic [3:0] S_ADV      = 4'd15;

  logic [3:0] state_q, state_d;
  logic [3:0] after_peaks;

  assign after_peaks = sts_i.last_px ? S_FL_TOP : S_ADV;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    pix_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        pix_ready_o = 1'b1;
        if (pix_valid_i) begin
          cmd_o.load  = 1'b1;
          cmd_o.j_clr = 1'b1;
          state_d     = S_RD_TOP;
        end
      end
      S_RD_TOP: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_RD_MID;
      end
      S_RD_MID: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_other = 1'b1;
        cmd_o.lat_top  = 1'b1;
        state_d        = S_SHIFT;
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        cmd_o.wr    = 1'b1;
        state_d     = S_CHK_A;
      end
      S_CHK_A: begin
        cmd_o.chk_go = 1'b1;
        cmd_o.chk    = lmd_pkg::CHK_A;
        cmd_o.chk_en = sts_i.r_ge1 && sts_i.c_ge1;
        state_d      = (sts_i.r_ge1 && sts_i.c_last) ? S_DUMMY : S_EMIT_A;
      end
      S_DUMMY: begin
        cmd_o.shift = 1'b1;
        state_d     = S_CHK_B;
      end
      S_CHK_B: begin
        cmd_o.chk_go = 1'b1;
        cmd_o.chk    = lmd_pkg::CHK_B;
        cmd_o.chk_en = 1'b1;
        state_d      = S_EMIT_A;
      end
      S_EMIT_A: begin
        if (!sts_i.hit_a) begin
          state_d = S_EMIT_B;
        end else if (sts_i.out_free) begin
          cmd_o.emit      = lmd_pkg::EMIT_SLOT_A;
          cmd_o.emit_last = !(sts_i.hit_b || sts_i.last_px);
          state_d         = S_EMIT_B;
        end
      end
      S_EMIT_B: begin
        if (!sts_i.hit_b) begin
          state_d = after_peaks;
        end else if (sts_i.out_free) begin
          cmd_o.emit      = lmd_pkg::EMIT_SLOT_B;
          cmd_o.emit_last = !sts_i.last_px;
          state_d         = after_peaks;
        end
      end
      S_FL_TOP: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_flush = 1'b1;
        cmd_o.rd_other = 1'b1;
        state_d        = S_FL_MID;
      end
      S_FL_MID: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_flush = 1'b1;
        cmd_o.lat_top  = 1'b1;
        state_d        = S_FL_SHIFT;
      end
      S_FL_SHIFT: begin
        cmd_o.shift = 1'b1;
        state_d     = S_FL_CHK;
      end
      S_FL_CHK: begin
        cmd_o.chk_go = 1'b1;
        cmd_o.chk    = lmd_pkg::CHK_F;
        cmd_o.chk_en = sts_i.j_ge1;
        state_d      = S_FL_EMIT;
      end
      S_FL_EMIT: begin
        if (!sts_i.hit_a || sts_i.out_free) begin
          if (sts_i.hit_a) begin
            cmd_o.emit = lmd_pkg::EMIT_SLOT_A;
          end
          if (sts_i.j_end) begin
            state_d = S_SUM;
          end else begin
            cmd_o.j_inc = 1'b1;
            state_d     = S_FL_TOP;
          end
        end
      end
      S_SUM: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = lmd_pkg::EMIT_SUM;
          cmd_o.emit_last = 1'b1;
          state_d         = S_ADV;
        end
      end
      S_ADV: begin
        cmd_o.advance = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

>>> design/local_maximum_3x3_detector_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// local_maximum_3x3_detector_top: streamed 3x3 strict local maximum detector
// Reports each strict local maximum of a row-major frame as soon as its
// window is complete, then a summary with the largest positive maximum.
// ----------------------------------------------------------------------------
// Pixels are taken one at a time; the single read port of the line store
//   (two reads per pixel) and the check sequence hold off the next pixel,
//   and the last column of every row after the first adds a second check.
//   Each report waits for a free output register.
// End of frame: after the last pixel the block re-reads the last two rows
//   and emits the summary.
// Reset: asynchronous, active low; frame size returns to 8 x 8, position
//   and best cleared. The line store is not cleared.
// ----------------------------------------------------------------------------
module local_maximum_3x3_detector_top #(
  parameter int unsigned MAX_COLS = 64
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  lmd_pix_if.sink  pix_i,
  lmd_rep_if.source rep_o,
  lmd_cfg_if.sink  cfg_i
);

  lmd_pkg::lmd_cmd_t cmd;
  lmd_pkg::lmd_sts_t sts;

  // register writes are taken at once; the user must send them only while idle, the block does not enforce it
  assign cfg_i.ready = 1'b1;

  // sequencer: one pixel at a time, hold input ready low until its beats go out
  lmd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_valid_i (pix_i.valid),
    .pix_ready_o (pix_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: line store, window, best tracker and the report register
  lmd_dp #(
    .MaxCols (MAX_COLS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .pix_value_i (pix_i.pixel_value),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .out_valid_o (rep_o.valid),
    .out_ready_i (rep_o.ready),
    .out_kind_o  (rep_o.report_kind),
    .out_value_o (rep_o.peak_value),
    .out_row_o   (rep_o.peak_row),
    .out_col_o   (rep_o.peak_col),
    .out_last_o  (rep_o.last_of_run)
  );

endmodule
`default_nettype wire

>>> design/lmd_chk.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmd_chk: port checker of the local maximum detector
// Watches the pixel and report channels over time.
// ----------------------------------------------------------------------------
module lmd_chk (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             pix_valid_i,
  input wire logic                             pix_ready_i,
  input wire logic                             rep_valid_i,
  input wire logic                             rep_ready_i,
  input wire logic [lmd_pkg::KindW-1:0]        rep_kind_i,
  input wire logic signed [lmd_pkg::PixW-1:0]  rep_value_i,
  input wire logic [lmd_pkg::RowW-1:0]         rep_row_i,
  input wire logic [lmd_pkg::ColW-1:0]         rep_col_i,
  input wire logic                             rep_last_i
);

  // one pixel in flight: ready drops after a taken beat
  a_one_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_valid_i && pix_ready_i |=> !pix_ready_i)
    else $error("pixel taken while previous pixel in flight");

  a_sum_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_valid_i && (rep_kind_i != lmd_pkg::KIND_PEAK) |-> rep_last_i)
    else $error("summary beat not marked last");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_valid_i && (rep_kind_i == lmd_pkg::KIND_NONE) |->
      (rep_value_i == '0) && (rep_row_i == '0) && (rep_col_i == '0))
    else $error("empty summary carries nonzero fields");

  a_rep_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_valid_i && !rep_ready_i |=> rep_valid_i && $stable(rep_kind_i) &&
      $stable(rep_value_i) && $stable(rep_row_i) && $stable(rep_col_i) &&
      $stable(rep_last_i))
    else $error("stalled report beat changed");

endmodule

bind local_maximum_3x3_detector_top lmd_chk u_lmd_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pix_valid_i (pix_i.valid),
  .pix_ready_i (pix_i.ready),
  .rep_valid_i (rep_o.valid),
  .rep_ready_i (rep_o.ready),
  .rep_kind_i  (rep_o.report_kind),
  .rep_value_i (rep_o.peak_value),
  .rep_row_i   (rep_o.peak_row),
  .rep_col_i   (rep_o.peak_col),
  .rep_last_i  (rep_o.last_of_run)
);
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stream testbench of the 3x3 local maximum detector
// Feeds pixel frames of assorted sizes, value mixes and handshake pressure,
// predicts every peak and summary beat from a behavioral copy of the
// detector and checks each report beat field by field in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LineCols  = 64;
  localparam int SettleCyc = 400;    // covers the end-of-frame flush of 64 columns
  localparam int StallLim  = 5000;   // cycles without any beat before giving up
  localparam int RandItems = 88;

  typedef struct {
    logic [lmd_pkg::KindW-1:0]       kind;
    logic signed [lmd_pkg::PixW-1:0] value;
    logic [lmd_pkg::RowW-1:0]        row;
    logic [lmd_pkg::ColW-1:0]        col;
    logic                            last;
  } report_t;

  // One directed step: a register write or a pixel; hand_kind other than
  // KIND_PEAK marks a 1x1 frame whose two reports are typed in directly.
  typedef struct {
    bit                              is_reg;
    logic [lmd_pkg::CfgIdxW-1:0]     idx;
    logic [31:0]                     data;
    logic [lmd_pkg::KindW-1:0]       hand_kind;
  } step_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  lmd_pix_if pix ();
  lmd_rep_if rep ();
  lmd_cfg_if cfg ();

  local_maximum_3x3_detector_top u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix),
    .rep_o (rep),
    .cfg_i (cfg)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the detector state
  logic signed [lmd_pkg::PixW-1:0] line_mem [2*LineCols];
  logic signed [lmd_pkg::PixW-1:0] evict [3];
  int                              row_pos, col_pos;
  logic signed [lmd_pkg::PixW-1:0] best_val;
  logic [lmd_pkg::RowW-1:0]        best_r;
  logic [lmd_pkg::ColW-1:0]        best_c;
  bit                              best_hit;
  logic [lmd_pkg::RowsW-1:0]       rows_reg = lmd_pkg::ResetRows;
  logic [lmd_pkg::ColsW-1:0]       cols_reg = lmd_pkg::ResetCols;

  report_t pending_reports [$];
  int      fails = 0;
  int      src_idle = 0;
  int      snk_stall = 0;
  int      quiet_cycles = 0;

  function automatic int frame_height();
    if (rows_reg == 0) return 1;
    if (rows_reg > lmd_pkg::MaxRows) return lmd_pkg::MaxRows;
    return rows_reg;
  endfunction

  function automatic int frame_width();
    if (cols_reg == 0) return 1;
    if (cols_reg > LineCols) return LineCols;
    return cols_reg;
  endfunction

  function automatic void clear_frame();
    row_pos  = 0;
    col_pos  = 0;
    best_val = '0;
    best_r   = '0;
    best_c   = '0;
    best_hit = 0;
  endfunction

  // Element (rr, cc) as seen while the pixel at (cr, ccur) is being taken
  function automatic logic signed [lmd_pkg::PixW-1:0] pixel_at(int cr, int ccur, int rr,
                                                               int cc);
    int d;
    if (rr + 2 == cr) begin
      d = ccur - cc;
      if (d < 0 || d > 2) return '0;
      return evict[d];
    end
    return line_mem[(rr & 1) * LineCols + (cc & (LineCols - 1))];
  endfunction

  function automatic void test_window(int cr, int ccur, int r, int c, int rows, int cols);
    logic signed [lmd_pkg::PixW-1:0] center;
    int nr, nc;
    report_t rp;
    center = pixel_at(cr, ccur, r, c);
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        nr = r + dr;
        nc = c + dc;
        if (dr == 0 && dc == 0) continue;
        if (nr < 0 || nr >= rows || nc < 0 || nc >= cols) continue;
        if (pixel_at(cr, ccur, nr, nc) >= center) return;
      end
    end
    rp = '{lmd_pkg::KIND_PEAK, center, lmd_pkg::RowW'(r), lmd_pkg::ColW'(c), 1'b0};
    pending_reports.push_back(rp);
    if (center > best_val) begin
      best_val = center;
      best_r   = lmd_pkg::RowW'(r);
      best_c   = lmd_pkg::ColW'(c);
      best_hit = 1;
    end
  endfunction

  // Advance the shadow by one pixel and queue the reports it causes
  function automatic void predict_pixel(logic signed [lmd_pkg::PixW-1:0] v);
    int rows, cols, r, c, n0, slot;
    report_t rp;
    rows = frame_height();
    cols = frame_width();
    n0   = pending_reports.size();
    if (row_pos >= rows || col_pos >= cols) begin
      row_pos = 0;
      col_pos = 0;
    end
    r = row_pos;
    c = col_pos;
    slot = (r & 1) * LineCols + (c & (LineCols - 1));
    evict[2] = evict[1];
    evict[1] = evict[0];
    evict[0] = line_mem[slot];
    line_mem[slot] = v;
    if (r >= 1) begin
      if (c >= 1) test_window(r, c, r - 1, c - 1, rows, cols);
      if (c == cols - 1) test_window(r, c, r - 1, c, rows, cols);
    end
    if (r == rows - 1 && c == cols - 1) begin
      for (int k = 0; k < cols; k++) test_window(r, c, r, k, rows, cols);
      if (best_hit) rp = '{lmd_pkg::KIND_BEST, best_val, best_r, best_c, 1'b0};
      else rp = '{lmd_pkg::KIND_NONE, '0, '0, '0, 1'b0};
      pending_reports.push_back(rp);
      clear_frame();
    end else if (c == cols - 1) begin
      col_pos = 0;
      row_pos++;
    end else begin
      col_pos++;
    end
    if (pending_reports.size() > n0)
      pending_reports[pending_reports.size() - 1].last = 1'b1;
  endfunction

  // Hold until the block has drained and the flush is surely over
  task automatic wait_drained();
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [lmd_pkg::CfgIdxW-1:0] idx, logic [31:0] data);
    wait_drained();
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(negedge clk_i); while (!cfg.ready);
    @(posedge clk_i);
    cfg.valid <= 1'b0;
    if (idx == lmd_pkg::REG_FRAME_ROWS) rows_reg = data[lmd_pkg::RowsW-1:0];
    else if (idx == lmd_pkg::REG_FRAME_COLS) cols_reg = data[lmd_pkg::ColsW-1:0];
    clear_frame();
  endtask

  // Offer one pixel beat; drop valid for a random gap first when idling
  task automatic send_pixel(logic signed [lmd_pkg::PixW-1:0] v,
                            logic [lmd_pkg::KindW-1:0] hand_kind);
    int n0;
    report_t rp;
    if ($urandom_range(99) < src_idle) begin
      pix.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle);
    end
    n0 = pending_reports.size();
    predict_pixel(v);
    if (hand_kind != lmd_pkg::KIND_PEAK) begin
      while (pending_reports.size() > n0) void'(pending_reports.pop_back());
      rp = '{lmd_pkg::KIND_PEAK, v, '0, '0, 1'b0};
      pending_reports.push_back(rp);
      rp = '{hand_kind, (hand_kind == lmd_pkg::KIND_BEST) ? v : '0, '0, '0, 1'b1};
      pending_reports.push_back(rp);
    end
    pix.valid       <= 1'b1;
    pix.pixel_value <= v;
    do @(negedge clk_i); while (!pix.ready);
    @(posedge clk_i);
  endtask

  task automatic end_pixels();
    pix.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [lmd_pkg::PixW-1:0] pick_value(int mix);
    case (mix)
      0: return lmd_pkg::PixW'($urandom_range(6)) - 3;            // plateaus and ties
      1: return $urandom;
      2: begin
        case ($urandom_range(4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: return -$signed(lmd_pkg::PixW'($urandom_range(1000))) - 1;  // all negative
    endcase
  endfunction

  // Directed steps: 1x1 frames with typed results, clamped sizes, a 3x3
  // center peak, an abandoned oversized frame and a flat 2x2 frame.
  step_t directed [] = '{
    '{1, lmd_pkg::REG_FRAME_ROWS, 32'd1, lmd_pkg::KIND_PEAK},
    '{1, lmd_pkg::REG_FRAME_COLS, 32'd1, lmd_pkg::KIND_PEAK},
    '{0, '0, 32'h7FFF_FFFF, lmd_pkg::KIND_BEST},
    '{0, '0, 32'h8000_0000, lmd_pkg::KIND_NONE},
    '{0, '0, 32'h0000_0000, lmd_pkg::KIND_NONE},
    '{0, '0, 32'h0000_0001, lmd_pkg::KIND_BEST},
    '{0, '0, 32'hFFFF_FFFF, lmd_pkg::KIND_NONE},
    '{1, lmd_pkg::REG_FRAME_COLS, 32'd0, lmd_pkg::KIND_PEAK},
    '{0, '0, 32'h0000_0005, lmd_pkg::KIND_BEST},
    '{1, lmd_pkg::REG_FRAME_ROWS, 32'hFFFF_F800, lmd_pkg::KIND_PEAK},
    '{0, '0, 32'h0000_0007, lmd_pkg::KIND_BEST},
    '{1, lmd_pkg::REG_FRAME_ROWS, 32'd3, lmd_pkg::KIND_PEAK},
    '{1, lmd_pkg::REG_FRAME_COLS, 32'd3, lmd_pkg::KIND_PEAK},
    '{0, '0, 32'd1, lmd_pkg::KIND_PEAK}, '{0, '0, 32'd2, lmd_pkg::KIND_PEAK},
    '{0, '0, 32'd3, lmd_pkg::KIND_PEAK}, '{0, '0, 32'd4, lmd_pkg::KIND_PEAK},
    '{0, '0, 32'd100, lmd_pkg::KIND_PEAK}, '{0, '0, 32'd6, lmd_pkg::KIND_PEAK},
    '{0, '0, 32'd7, lmd_pkg::KIND_PEAK}, '{0, '0, 32'd8, lmd_pkg::KIND_PEAK},
    '{0, '0, 32'd9, lmd_pkg::KIND_PEAK},
    '{1, lmd_pkg::REG_FRAME_COLS, 32'd127, lmd_pkg::KIND_PEAK},
    '{1, lmd_pkg::REG_FRAME_ROWS, 32'd2047, lmd_pkg::KIND_PEAK},
    '{0, '0, 32'h8000_0000, lmd_pkg::KIND_PEAK},
    '{0, '0, 32'h7FFF_FFFF, lmd_pkg::KIND_PEAK},
    '{1, lmd_pkg::REG_FRAME_ROWS, 32'd2, lmd_pkg::KIND_PEAK},
    '{1, lmd_pkg::REG_FRAME_COLS, 32'd2, lmd_pkg::KIND_PEAK},
    '{0, '0, 32'd4, lmd_pkg::KIND_PEAK}, '{0, '0, 32'd4, lmd_pkg::KIND_PEAK},
    '{0, '0, 32'd4, lmd_pkg::KIND_PEAK}, '{0, '0, 32'd4, lmd_pkg::KIND_PEAK}
  };

  // Receiver: drop ready at random under the current stall rate
  always @(posedge clk_i) begin
    rep.ready <= ($urandom_range(99) >= snk_stall);
  end

  // Check each report beat at the negedge before the edge that takes it
  always @(negedge clk_i) begin
    report_t want;
    if (rst_ni) begin
      if (pix.valid && pix.ready || rep.valid && rep.ready || cfg.valid && cfg.ready)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (rep.valid && rep.ready) begin
        if (pending_reports.size() == 0) begin
          $error("report beat with nothing expected: kind %0d value %0d",
                 rep.report_kind, rep.peak_value);
          fails++;
        end else begin
          want = pending_reports.pop_front();
          if (rep.report_kind !== want.kind) begin
            $error("report_kind: expected %0d, got %0d", want.kind, rep.report_kind);
            fails++;
          end
          if (rep.peak_value !== want.value) begin
            $error("peak_value: expected %0d, got %0d", want.value, rep.peak_value);
            fails++;
          end
          if (rep.peak_row !== want.row) begin
            $error("peak_row: expected %0d, got %0d", want.row, rep.peak_row);
            fails++;
          end
          if (rep.peak_col !== want.col) begin
            $error("peak_col: expected %0d, got %0d", want.col, rep.peak_col);
            fails++;
          end
          if (rep.last_of_run !== want.last) begin
            $error("last_of_run: expected %0d, got %0d", want.last, rep.last_of_run);
            fails++;
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing has moved for too long
  always @(posedge clk_i) begin
    if (quiet_cycles >= StallLim) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int taken, frame_len, stop_at, mix, phase;
    bit restart;
    pix.valid       = 1'b0;
    pix.pixel_value = '0;
    cfg.valid       = 1'b0;
    cfg.index       = '0;
    cfg.data        = '0;
    rep.ready       = 1'b0;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (evict[i]) evict[i] = '0;
    clear_frame();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, no idling
    foreach (directed[i]) begin
      if (directed[i].is_reg) begin
        end_pixels();
        write_reg(directed[i].idx, directed[i].data);
      end else begin
        send_pixel(directed[i].data, directed[i].hand_kind);
      end
    end
    end_pixels();

    // Random frames, walking through the idling phases
    taken   = 0;
    restart = 1;
    while (taken < RandItems) begin
      phase = taken * 4 / RandItems;
      case (phase)
        0: begin src_idle = 0;  snk_stall = 0;  end
        1: begin src_idle = 70; snk_stall = 0;  end
        2: begin src_idle = 0;  snk_stall = 70; end
        default: begin src_idle = 37; snk_stall = 37; end
      endcase
      if (restart || $urandom_range(2) == 0) begin
        end_pixels();
        if ($urandom_range(9) == 0) begin
          write_reg(lmd_pkg::REG_FRAME_ROWS, {$urandom} & ~32'h7FF | $urandom_range(1, 2));
          write_reg(lmd_pkg::REG_FRAME_COLS, 32'd64);
        end else begin
          write_reg(lmd_pkg::REG_FRAME_ROWS, $urandom_range(1, 4));
          write_reg(lmd_pkg::REG_FRAME_COLS, {$urandom} & ~32'h7F | $urandom_range(1, 6));
        end
      end
      frame_len = frame_height() * frame_width();
      // Abandon one frame in ten part way through
      restart = ($urandom_range(9) == 0) && frame_len > 1;
      stop_at = restart ? $urandom_range(1, frame_len - 1) : frame_len;
      mix = $urandom_range(3);
      for (int k = 0; k < stop_at && taken < RandItems; k++) begin
        send_pixel(pick_value(mix), lmd_pkg::KIND_PEAK);
        taken++;
      end
    end
    end_pixels();

    wait_drained();
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/lmd_pkg.sv
design/lmd_if.sv
design/lmd_ram.sv
design/lmd_dp.sv
design/lmd_ctrl.sv
design/local_maximum_3x3_detector_top.sv
design/lmd_chk.sv
dv/tb_top.sv
